>>> rtl/core/hcmb_pkg.sv
package hcmb_pkg;

   localparam int BOOT_ROM_DEPTH = 256;
   localparam int DMA_LENGTH     = 160;
   localparam int MEM_DEPTH      = 65536;
   localparam int MEM_AW         = $clog2(MEM_DEPTH);
   localparam int BOOT_AW        = $clog2(BOOT_ROM_DEPTH);
   localparam int DMA_CW         = $clog2(DMA_LENGTH);

   localparam logic [1:0] CMD_READ      = 2'd0;
   localparam logic [1:0] CMD_WRITE     = 2'd1;
   localparam logic [1:0] CMD_BUTTON    = 2'd2;
   localparam logic [1:0] CMD_BOOT_LOAD = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [2:0]  button;
      logic        pressed;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       joypad_irq;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic echo_step;
      logic dma_read;
      logic dma_write;
      logic load_read;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_read;
      logic is_echo;
      logic is_dma;
      logic clear_last;
      logic dma_last;
   } dp_status_type;

endpackage

>>> rtl/core/hcmb_controller.sv
module hcmb_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  hcmb_pkg::dp_status_type status,
   output hcmb_pkg::dp_cmd_type    cmd
);
   import hcmb_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_ECHO   = 3'd3;
   localparam logic [2:0] ST_DMA_RD = 3'd4;
   localparam logic [2:0] ST_DMA_WR = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.accept     = accept;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (status.is_read)      state_in = ST_READ;
               else if (status.is_echo) state_in = ST_ECHO;
               else if (status.is_dma)  state_in = ST_DMA_RD;
            end
         end
         ST_READ: begin
            // memory data is registered; wait for the output slot
            cmd.load_read = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         ST_ECHO: begin
            cmd.echo_step = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_DMA_RD: begin
            cmd.dma_read = 1'b1;
            state_in     = ST_DMA_WR;
         end
         ST_DMA_WR: begin
            cmd.dma_write = 1'b1;
            state_in      = status.dma_last ? ST_IDLE : ST_DMA_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((accept && !status.is_read) || cmd.load_read) rsp_valid_in = 1'b1;
      else if (rsp_ready)                               rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/hcmb_datapath.sv
module hcmb_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  hcmb_pkg::dp_cmd_type    cmd,
   output hcmb_pkg::dp_status_type status,
   input  hcmb_pkg::req_type       req_payload,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   output hcmb_pkg::rsp_type       rsp_payload
);
   import hcmb_pkg::*;

   localparam logic [15:0] ADDR_JOYP     = 16'hFF00;
   localparam logic [15:0] ADDR_DIV      = 16'hFF04;
   localparam logic [15:0] ADDR_TAC      = 16'hFF07;
   localparam logic [15:0] ADDR_IF       = 16'hFF0F;
   localparam logic [15:0] ADDR_STAT     = 16'hFF41;
   localparam logic [15:0] ADDR_LY       = 16'hFF44;
   localparam logic [15:0] ADDR_DMA      = 16'hFF46;
   localparam logic [15:0] ADDR_BOOT     = 16'hFF50;
   localparam logic [15:0] ADDR_IE       = 16'hFFFF;
   localparam logic [15:0] ECHO_LO       = 16'hE000;
   localparam logic [15:0] ECHO_HI       = 16'hFDFF;
   localparam logic [15:0] ECHO_OFFSET   = 16'h2000;
   localparam logic [15:0] UNUSABLE_LO   = 16'hFEA0;
   localparam logic [15:0] UNUSABLE_HI   = 16'hFEFF;
   localparam logic [7:0]  OAM_PAGE      = 8'hFE;
   localparam logic [7:0]  TAC_FILL      = 8'hF8;
   localparam logic [7:0]  IRQ_MASK      = 8'h1F;
   localparam logic [4:0]  IRQ_JOYPAD    = 5'h10;
   localparam logic [7:0]  BOOT_UNMAP    = 8'h01;
   localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_DEPTH - 1);
   localparam logic [DMA_CW-1:0] DMA_LAST = DMA_CW'(DMA_LENGTH - 1);

   localparam logic [2:0] SRC_MEM  = 3'd0;
   localparam logic [2:0] SRC_BOOT = 3'd1;
   localparam logic [2:0] SRC_ZERO = 3'd2;
   localparam logic [2:0] SRC_JOY  = 3'd3;
   localparam logic [2:0] SRC_IF   = 3'd4;
   localparam logic [2:0] SRC_STAT = 3'd5;
   localparam logic [2:0] SRC_BREG = 3'd6;

   typedef struct packed {
      logic [2:0]        sel;
      logic [MEM_AW-1:0] addr;
   } route_type;

   function automatic logic in_echo(input logic [15:0] a);
      return (a >= ECHO_LO) && (a <= ECHO_HI);
   endfunction

   function automatic logic in_unusable(input logic [15:0] a);
      return (a >= UNUSABLE_LO) && (a <= UNUSABLE_HI);
   endfunction

   function automatic route_type route(input logic [15:0] a, input logic overlay_on);
      route_type r;
      r.sel  = SRC_MEM;
      r.addr = a;
      if (overlay_on && (a[15:8] == 8'h00)) begin
         r.sel = SRC_BOOT;
      end else if (in_echo(a)) begin
         r.addr = a - ECHO_OFFSET;
      end else if (in_unusable(a)) begin
         r.sel = SRC_ZERO;
      end else begin
         case (a)
            ADDR_JOYP: r.sel = SRC_JOY;
            ADDR_IF:   r.sel = SRC_IF;
            ADDR_STAT: r.sel = SRC_STAT;
            ADDR_BOOT: r.sel = SRC_BREG;
            default:   r.sel = SRC_MEM;
         endcase
      end
      return r;
   endfunction

   logic [7:0] mem  [0:MEM_DEPTH-1];
   logic [7:0] brom [0:BOOT_ROM_DEPTH-1];

   logic [7:0]        mem_rdata_ff, brom_rdata_ff;
   logic [2:0]        src_sel_ff;
   logic [MEM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [DMA_CW-1:0] dma_cnt_ff, dma_cnt_in;
   logic [15:0]       pend_addr_ff;
   logic [7:0]        pend_data_ff;
   logic [1:0]        joy_sel_ff, joy_sel_in;
   logic [3:0]        action_ff, action_in;
   logic [3:0]        dpad_ff, dpad_in;
   logic [4:0]        if_ff, if_in;
   logic [3:0]        stat_ff, stat_in;     // STAT bits 6:3, the rest stay zero
   logic [7:0]        breg_ff, breg_in;
   logic              boot_mapped_ff, boot_mapped_in;
   rsp_type           rsp_ff, rsp_in;

   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              wr_en;
   logic [7:0]        wr_val;
   logic              brom_we;
   logic              rd_en;
   logic [15:0]       rd_addr;
   route_type         rd_route;
   logic [7:0]        read_value;
   logic [7:0]        joy_value;
   logic [3:0]        joy_low;
   logic [3:0]        bit_mask, group_old, group_new;
   logic              irq;
   logic              is_read;

   assign is_read = (req_payload.command == CMD_READ);

   assign status.is_read    = is_read;
   assign status.is_echo    = (req_payload.command == CMD_WRITE) && in_echo(req_payload.address);
   assign status.is_dma     = (req_payload.command == CMD_WRITE) &&
                              (req_payload.address == ADDR_DMA);
   assign status.clear_last = (clr_cnt_ff == MEM_LAST);
   assign status.dma_last   = (dma_cnt_ff == DMA_LAST);

   // pressed buttons are zero bits
   always_comb begin
      joy_low = 4'hF;
      if (!joy_sel_ff[0]) joy_low = joy_low & action_ff;
      if (!joy_sel_ff[1]) joy_low = joy_low & dpad_ff;
      joy_value = {2'b11, joy_sel_ff, joy_low};
   end

   always_comb begin
      case (src_sel_ff)
         SRC_MEM:  read_value = mem_rdata_ff;
         SRC_BOOT: read_value = brom_rdata_ff;
         SRC_JOY:  read_value = joy_value;
         SRC_IF:   read_value = {3'b000, if_ff};
         SRC_STAT: read_value = {1'b0, stat_ff, 3'b000};
         SRC_BREG: read_value = breg_ff;
         default:  read_value = 8'h00;
      endcase
   end

   assign rd_en    = (cmd.accept && is_read) || cmd.dma_read;
   assign rd_addr  = cmd.dma_read ? {pend_data_ff, 8'(dma_cnt_ff)}
                                  : req_payload.address;
   assign rd_route = route(rd_addr, boot_mapped_ff && (breg_ff == 8'h00));

   assign bit_mask  = 4'b0001 << req_payload.button[1:0];
   assign group_old = req_payload.button[2] ? action_ff : dpad_ff;
   assign group_new = req_payload.pressed ? (group_old & ~bit_mask) : (group_old | bit_mask);

   always_comb begin
      joy_sel_in     = joy_sel_ff;
      action_in      = action_ff;
      dpad_in        = dpad_ff;
      if_in          = if_ff;
      stat_in        = stat_ff;
      breg_in        = breg_ff;
      boot_mapped_in = boot_mapped_ff;
      wr_en          = 1'b0;
      wr_val         = req_payload.write_data;
      brom_we        = 1'b0;
      irq            = 1'b0;
      if (cmd.accept) begin
         case (req_payload.command)
            CMD_WRITE: begin
               if (boot_mapped_ff && (req_payload.address == ADDR_BOOT) &&
                   (req_payload.write_data == BOOT_UNMAP)) boot_mapped_in = 1'b0;
               case (req_payload.address)
                  ADDR_JOYP: joy_sel_in = req_payload.write_data[5:4];
                  ADDR_DIV, ADDR_LY: begin
                     wr_en  = 1'b1;
                     wr_val = 8'h00;
                  end
                  ADDR_TAC: begin
                     wr_en  = 1'b1;
                     wr_val = req_payload.write_data | TAC_FILL;
                  end
                  ADDR_IE: begin
                     wr_en  = 1'b1;
                     wr_val = req_payload.write_data & IRQ_MASK;
                  end
                  ADDR_IF:   if_in   = req_payload.write_data[4:0];
                  ADDR_STAT: stat_in = req_payload.write_data[6:3];
                  ADDR_BOOT: breg_in = req_payload.write_data;
                  default:   wr_en   = !in_unusable(req_payload.address);
               endcase
            end
            CMD_BUTTON: begin
               if (req_payload.button[2]) action_in = group_new;
               else                       dpad_in   = group_new;
               // new press: bit was released and is now held
               irq = ((group_old & bit_mask) != 4'h0) && req_payload.pressed;
               if (irq) if_in = if_ff | IRQ_JOYPAD;
            end
            CMD_BOOT_LOAD: brom_we = 1'b1;
            default: ;
         endcase
      end
      if (csr_write_enable) boot_mapped_in = csr_write_data;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_payload.address;
      mem_wdata = wr_val;
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = 8'h00;
      end else if (cmd.accept && wr_en) begin
         mem_we = 1'b1;
      end else if (cmd.echo_step) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = pend_data_ff;
      end else if (cmd.dma_write) begin
         mem_we    = 1'b1;
         mem_waddr = {OAM_PAGE, 8'(dma_cnt_ff)};
         mem_wdata = read_value;
      end
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      dma_cnt_in = dma_cnt_ff;
      rsp_in     = rsp_ff;
      if (cmd.clear_step) clr_cnt_in = clr_cnt_ff + 1'b1;
      if (cmd.accept)         dma_cnt_in = '0;
      else if (cmd.dma_write) dma_cnt_in = dma_cnt_ff + 1'b1;
      if (cmd.accept && !is_read) begin
         rsp_in.read_data  = 8'h00;
         rsp_in.joypad_irq = irq;
      end else if (cmd.load_read) begin
         rsp_in.read_data  = read_value;
         rsp_in.joypad_irq = 1'b0;
      end
   end

   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (rd_en)  mem_rdata_ff   <= mem[rd_route.addr];
   end

   always_ff @(posedge clock) begin
      if (brom_we) brom[req_payload.address[BOOT_AW-1:0]] <= req_payload.write_data;
      if (rd_en)   brom_rdata_ff <= brom[rd_addr[BOOT_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rd_en) src_sel_ff <= rd_route.sel;
      if (cmd.accept) begin
         pend_addr_ff <= req_payload.address - ECHO_OFFSET;
         pend_data_ff <= req_payload.write_data;
      end
      rsp_ff     <= rsp_in;
      dma_cnt_ff <= dma_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff     <= '0;
         joy_sel_ff     <= 2'b11;
         action_ff      <= 4'hF;
         dpad_ff        <= 4'hF;
         if_ff          <= '0;
         stat_ff        <= '0;
         breg_ff        <= '0;
         boot_mapped_ff <= 1'b0;
      end else begin
         clr_cnt_ff     <= clr_cnt_in;
         joy_sel_ff     <= joy_sel_in;
         action_ff      <= action_in;
         dpad_ff        <= dpad_in;
         if_ff          <= if_in;
         stat_ff        <= stat_in;
         breg_ff        <= breg_in;
         boot_mapped_ff <= boot_mapped_in;
      end
   end

endmodule

>>> rtl/core/handheld_console_memory_bus_top.sv
// Channel     Direction  Handshake            Payload
// req_        in         req_valid/req_ready  hcmb_pkg::req_type
// rsp_        out        rsp_valid/rsp_ready  hcmb_pkg::rsp_type
// csr_        in         csr_write_enable     csr_write_data (boot overlay enable)
//
// Write, button event and boot ROM load: result registered on accept. Read: registered
// memory port, then output register. Echo write: echo address, then its mirror, on the
// single memory write port. DMA write: a memory read and write per byte, 160 bytes.
// After reset a clearing pass writes all 65536 memory bytes, with req_ready low.
// A result waits in the output register; a new transaction is taken as it drains.
module handheld_console_memory_bus_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hcmb_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hcmb_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);
   import hcmb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   hcmb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hcmb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_payload      (rsp_payload)
   );

   // input is only taken when the output slot is free or draining
   a_ready_needs_slot: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("req_ready while output slot is blocked");

   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_payload.command == CMD_READ)) |=> !req_ready)
      else $error("transaction accepted during a read");

   a_nonread_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_payload.command != CMD_READ)) |=> rsp_valid)
      else $error("missing result after non-read transaction");

endmodule
